/* hw/rtl/gbim_pkg.sv */
// gbim_pkg: shared types, codes and defaults of the genome bin index mapper
// no dependencies; used by every module of the block but gbim_ram
package gbim_pkg;

    localparam int FIELD_W = 32;
    localparam int BIN_W   = 40;
    localparam int ID_W    = 8;

    localparam int MAX_REFS_DEF     = 256;
    localparam int REF_ID_SPACE_DEF = 256;
    localparam int POS_BITS_DEF     = 32;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
    localparam logic [1:0] STATUS_BEYOND  = 2'd2;
    localparam logic [1:0] STATUS_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [ID_W-1:0]    ref_id;
        logic [FIELD_W-1:0] ref_length;
        logic [FIELD_W-1:0] position;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [BIN_W-1:0]   bin_index;
        logic [FIELD_W-1:0] offset;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic       init_write;
        logic       capture;
        logic       tbl_clear;
        logic       load_write;
        logic       id_read;
        logic       slot_read;
        logic       div_start;
        logic       total_add;
        logic       res_lookup;
        logic       res_set;
        logic [1:0] res_code;
        logic       out_push;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       init_last;
        logic [1:0] op;
        logic       id_oob;
        logic       full;
        logic       slot_ok;
        logic       pos_past;
        logic       div_done;
    } sts_t;

endpackage

/* hw/rtl/gbim_ram.sv */
// gbim_ram: generic single write port, single read port ram, registered read
// no dependencies
module gbim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/gbim_div.sv */
// gbim_div: restoring divider, one quotient bit per cycle
// depends on gbim_pkg for the divisor width
module gbim_div #(
    parameter int NW = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [NW-1:0]               dividend,
    input  logic [gbim_pkg::FIELD_W-1:0] divisor,
    output logic                        done,
    output logic [NW-1:0]               quotient,
    output logic [gbim_pkg::FIELD_W-1:0] remainder
);

    localparam int DW   = gbim_pkg::FIELD_W;
    localparam int CNTW = $clog2(NW + 1);

    logic [DW-1:0]   rem_reg;
    logic [NW-1:0]   quo_reg;
    logic [DW-1:0]   dvs_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // no borrow: the divisor fits into the partial remainder
            if (!diff[DW+1])
            begin
                rem_reg <= diff[DW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* hw/rtl/gbim_ctrl.sv */
// gbim_ctrl: sequencer of the mapper, one item at a time
// depends on gbim_pkg for the command and status structs and the codes
module gbim_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    input  gbim_pkg::sts_t  sts,
    output gbim_pkg::cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECODE   = 7'b0000010,
        S_LKP_SLOT = 7'b0000100,
        S_LKP_CHK  = 7'b0001000,
        S_DIV      = 7'b0010000,
        S_FINISH   = 7'b0100000,
        S_INIT     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                // zero the id map, one entry per cycle
                cmd.init_write = 1'b1;
                if (sts.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.op)
                    gbim_pkg::OP_LOAD:
                    begin
                        if (sts.id_oob)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = gbim_pkg::STATUS_UNKNOWN;
                            state_next   = S_FINISH;
                        end
                        else if (sts.full)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = gbim_pkg::STATUS_FULL;
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            cmd.load_write = 1'b1;
                            cmd.div_start  = 1'b1;
                            state_next     = S_DIV;
                        end
                    end
                    gbim_pkg::OP_LOOKUP:
                    begin
                        if (sts.id_oob)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = gbim_pkg::STATUS_UNKNOWN;
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            cmd.id_read = 1'b1;
                            state_next  = S_LKP_SLOT;
                        end
                    end
                    gbim_pkg::OP_CLEAR:
                    begin
                        cmd.tbl_clear = 1'b1;
                        cmd.res_set   = 1'b1;
                        cmd.res_code  = gbim_pkg::STATUS_OK;
                        state_next    = S_FINISH;
                    end
                    default:
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = gbim_pkg::STATUS_OK;
                        state_next   = S_FINISH;
                    end
                endcase
            end
            S_LKP_SLOT:
            begin
                cmd.slot_read = 1'b1;
                state_next    = S_LKP_CHK;
            end
            S_LKP_CHK:
            begin
                if (!sts.slot_ok)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = gbim_pkg::STATUS_UNKNOWN;
                    state_next   = S_FINISH;
                end
                else if (sts.pos_past)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = gbim_pkg::STATUS_BEYOND;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    if (sts.op == gbim_pkg::OP_LOAD)
                    begin
                        cmd.total_add = 1'b1;
                    end
                    else
                    begin
                        cmd.res_lookup = 1'b1;
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // wait for the output word to be free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.out_push = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_push)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

/* hw/rtl/gbim_dp.sv */
// gbim_dp: datapath of the mapper: bin width register, id and slot rams,
// entry count, bin total, shared divider and result registers
// depends on gbim_pkg, gbim_ram and gbim_div
module gbim_dp #(
    parameter int MAX_REFS     = gbim_pkg::MAX_REFS_DEF,
    parameter int REF_ID_SPACE = gbim_pkg::REF_ID_SPACE_DEF,
    parameter int POS_BITS     = gbim_pkg::POS_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr,
    input  logic [gbim_pkg::FIELD_W-1:0] cfg_data,
    input  gbim_pkg::req_t               req,
    output gbim_pkg::rsp_t               rsp,
    input  gbim_pkg::cmd_t               cmd,
    output gbim_pkg::sts_t               sts
);

    localparam int FW  = gbim_pkg::FIELD_W;
    localparam int BW  = gbim_pkg::BIN_W;
    localparam int IDW = gbim_pkg::ID_W;
    localparam int PW  = (POS_BITS < FW) ? POS_BITS : FW;
    localparam int SW  = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int CW  = $clog2(MAX_REFS + 1);
    localparam int IW  = (REF_ID_SPACE > 1) ? $clog2(REF_ID_SPACE) : 1;
    localparam int EW  = IDW + PW + BW;

    logic [FW-1:0]  bw_reg;
    logic [1:0]     op_reg;
    logic [IDW-1:0] id_reg;
    logic [PW-1:0]  len_reg;
    logic [PW-1:0]  pos_reg;
    logic [CW-1:0]  count_reg;
    logic [BW-1:0]  total_reg;
    logic [IW-1:0]  init_cnt_reg;
    logic [1:0]     res_status_reg;
    logic [BW-1:0]  res_bin_reg;
    logic [FW-1:0]  res_off_reg;
    gbim_pkg::rsp_t out_reg;

    logic [IW+IDW-1:0] idx_wide;
    logic [IW-1:0]     idx;
    logic              id_wr_en;
    logic [IW-1:0]     id_wr_addr;
    logic [SW-1:0]     id_wr_data;
    logic [FW-1:0]     width_eff;
    logic [SW-1:0]     id_rd;
    logic [EW-1:0]     slot_wr;
    logic [EW-1:0]     slot_rd;
    logic [IDW-1:0]    slot_id;
    logic [PW-1:0]     slot_len;
    logic [BW-1:0]     slot_start;
    logic              div_done;
    logic [PW-1:0]     quo;
    logic [FW-1:0]     rem;
    logic [PW-1:0]     dividend;

    assign idx_wide   = {{IW{1'b0}}, id_reg};
    assign idx        = idx_wide[IW-1:0];
    // a zero width counts as one
    assign width_eff  = (bw_reg == '0) ? FW'(1) : bw_reg;
    assign slot_wr    = {id_reg, len_reg, total_reg};
    assign slot_id    = slot_rd[EW-1 -: IDW];
    assign slot_len   = slot_rd[BW+PW-1:BW];
    assign slot_start = slot_rd[BW-1:0];
    assign dividend   = (op_reg == gbim_pkg::OP_LOAD) ? len_reg : pos_reg;

    assign id_wr_en   = cmd.load_write || cmd.init_write;
    assign id_wr_addr = cmd.init_write ? init_cnt_reg : idx;
    assign id_wr_data = cmd.init_write ? '0 : count_reg[SW-1:0];

    // id map: zeroed once after reset, not on clear; a hit needs the slot
    // below the count and the slot's stored id to match, so stale entries
    // never answer
    gbim_ram #(
        .WIDTH (SW),
        .DEPTH (REF_ID_SPACE)
    ) u_id_ram (
        .clk     (clk),
        .wr_en   (id_wr_en),
        .wr_addr (id_wr_addr),
        .wr_data (id_wr_data),
        .rd_en   (cmd.id_read),
        .rd_addr (idx),
        .rd_data (id_rd)
    );

    gbim_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_REFS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (cmd.load_write),
        .wr_addr (count_reg[SW-1:0]),
        .wr_data (slot_wr),
        .rd_en   (cmd.slot_read),
        .rd_addr (id_rd),
        .rd_data (slot_rd)
    );

    gbim_div #(
        .NW (PW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dividend),
        .divisor   (width_eff),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    assign sts.init_last = (init_cnt_reg == IW'(REF_ID_SPACE - 1));
    assign sts.op        = op_reg;
    assign sts.id_oob    = (FW'(id_reg) >= FW'(REF_ID_SPACE));
    assign sts.full      = (count_reg == CW'(MAX_REFS));
    assign sts.slot_ok   = ({{CW{1'b0}}, id_rd} < {{SW{1'b0}}, count_reg})
                           && (slot_id == id_reg);
    assign sts.pos_past  = (pos_reg >= slot_len);
    assign sts.div_done  = div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg       <= FW'(1);
            count_reg    <= '0;
            total_reg    <= '0;
            init_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                bw_reg <= cfg_data;
            end
            if (cmd.init_write)
            begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
            end
            if (cmd.tbl_clear)
            begin
                count_reg <= '0;
                total_reg <= '0;
            end
            else if (cmd.load_write)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.total_add)
            begin
                // ceil(length / width)
                total_reg <= total_reg + BW'(quo) + BW'(rem != '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= req.op;
            id_reg  <= req.ref_id;
            len_reg <= req.ref_length[PW-1:0];
            pos_reg <= req.position[PW-1:0];
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_code;
            res_bin_reg    <= '0;
            res_off_reg    <= '0;
        end
        else if (cmd.load_write)
        begin
            res_status_reg <= gbim_pkg::STATUS_OK;
            res_bin_reg    <= total_reg;
            res_off_reg    <= '0;
        end
        else if (cmd.res_lookup)
        begin
            res_status_reg <= gbim_pkg::STATUS_OK;
            res_bin_reg    <= BW'(quo) + slot_start;
            res_off_reg    <= rem;
        end
        if (cmd.out_push)
        begin
            out_reg.status    <= res_status_reg;
            out_reg.bin_index <= res_bin_reg;
            out_reg.offset    <= res_off_reg;
        end
    end

    assign rsp = out_reg;

endmodule

/* hw/rtl/genome_bin_index_mapper_core.sv */
// genome_bin_index_mapper_core: top level of the genome bin index mapper
// depends on gbim_pkg, gbim_ctrl and gbim_dp
//
//   channel  | signals                   | moves
//   ---------+---------------------------+--------------------------------
//   req      | req_valid, req_stall, req | op, ref_id, ref_length, position
//   rsp      | rsp_valid, rsp_stall, rsp | status, bin_index, offset
//   cfg      | cfg_valid, cfg_ready,     | bin_width
//            | cfg_data                  |
//
// one item in flight; the shared divider makes one quotient bit per cycle
// load and lookup pass through the divider, errors, clear and unused ops do not;
// POS_BITS is capped at 32
// a new word is taken while the previous result still waits in the output
// register; a stalled result holds the block in its last step
// after reset a clearing pass zeroes every id map entry, req_stall high
module genome_bin_index_mapper_core #(
    parameter int MAX_REFS     = gbim_pkg::MAX_REFS_DEF,
    parameter int REF_ID_SPACE = gbim_pkg::REF_ID_SPACE_DEF,
    parameter int POS_BITS     = gbim_pkg::POS_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  gbim_pkg::req_t               req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output gbim_pkg::rsp_t               rsp,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [gbim_pkg::FIELD_W-1:0] cfg_data
);

    gbim_pkg::cmd_t cmd;
    gbim_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    gbim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    gbim_dp #(
        .MAX_REFS     (MAX_REFS),
        .REF_ID_SPACE (REF_ID_SPACE),
        .POS_BITS     (POS_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .req      (req),
        .rsp      (rsp),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

/* hw/rtl/gbim_chk.sv */
// gbim_chk: port-level checks of the mapper, bound to the top level
// depends on gbim_pkg and genome_bin_index_mapper_core
module gbim_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_stall,
    input gbim_pkg::req_t               req,
    input logic                         rsp_valid,
    input logic                         rsp_stall,
    input gbim_pkg::rsp_t               rsp
);

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result word changed while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second word taken while an item is in work");

    // a new result only comes out of a busy block
    a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result appeared without an item in work");

    // error results carry zero fields
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != gbim_pkg::STATUS_OK)
        |-> (rsp.bin_index == '0) && (rsp.offset == '0))
        else $error("error result with nonzero fields");

    // clear answers with an all-zero ok result when the output is free
    a_clear_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.op == gbim_pkg::OP_CLEAR) && !rsp_valid
        |-> ##3 rsp_valid && (rsp.status == gbim_pkg::STATUS_OK)
            && (rsp.bin_index == '0) && (rsp.offset == '0))
        else $error("clear did not answer with an all-zero ok result");

endmodule

bind genome_bin_index_mapper_core gbim_chk u_gbim_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
